[sv/sc2kc_pkg.sv]
// ---------------------------------------------------------------------------
// sc2kc_pkg
// Shared types and constants for the set-1 scancode to keycode translator.
// ---------------------------------------------------------------------------
`default_nettype none

package sc2kc_pkg;

  // Input commands.
  localparam logic [1:0] CMD_SCAN   = 2'd0;
  localparam logic [1:0] CMD_WR_MAIN = 2'd1;
  localparam logic [1:0] CMD_WR_EXT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RAW_MODE      = 2'd0;
  localparam logic [1:0] CFG_REBOOT_ENABLE = 2'd1;
  localparam logic [1:0] CFG_TABLE_VALID   = 2'd2;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_LED    = 2'd1,
    KIND_REBOOT = 2'd2,
    KIND_DEBUG  = 2'd3
  } kind_t;

  // Special scancodes.
  localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
  localparam logic [7:0] SC_DEBUG     = 8'hD4;
  localparam logic [7:0] SC_DELETE    = 8'h53;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_NUM       = 8'h45;
  localparam logic [7:0] SC_SCROLL    = 8'h46;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_BREAK     = 8'h80;

  // Modifier bit positions.
  localparam logic [2:0] M_LSHIFT = 3'd0;
  localparam logic [2:0] M_LALT   = 3'd1;
  localparam logic [2:0] M_LCTRL  = 3'd2;
  localparam logic [2:0] M_RSHIFT = 3'd3;
  localparam logic [2:0] M_RALT   = 3'd4;
  localparam logic [2:0] M_RCTRL  = 3'd5;

  // Lock LED bits.
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  // Shift-state columns.
  localparam logic [3:0] COL_NORMAL    = 4'd0;
  localparam logic [3:0] COL_SHIFT     = 4'd1;
  localparam logic [3:0] COL_CTRL      = 4'd2;
  localparam logic [3:0] COL_ALT       = 4'd3;
  localparam logic [3:0] COL_ALTGR     = 4'd4;
  localparam logic [3:0] COL_SHIFTCTRL = 4'd5;
  localparam logic [3:0] COL_SHIFTCAPS = 4'd6;
  localparam logic [3:0] COL_SHIFTNUM  = 4'd7;
  localparam logic [3:0] COL_CAPSLOCK  = 4'd8;
  localparam logic [3:0] COL_NUMLOCK   = 4'd9;

  // Maximum number of result words per input word.
  localparam int unsigned MAX_RESULTS = 3;

endpackage

`default_nettype wire

[sv/scancode_to_keycode_translator_unit.sv]
// ---------------------------------------------------------------------------
// scancode_to_keycode_translator_unit
// Translates PC set-1 scancodes to key bytes through loadable keymap tables.
// ---------------------------------------------------------------------------
// The keymap memory is read at the edge that accepts a scancode, into the
// lookup stage; the result list is built from it and registered into the
// three-entry output buffer once that buffer is free. Results leave one word
// per cycle while out_ready is high. Table loads produce no result words. The
// input side can accept one more word into the lookup stage while results
// drain, and then stalls until the last result word is taken. The keymap
// tables have no reset and must be loaded before they are used.
`default_nettype none

module scancode_to_keycode_translator_unit #(
  parameter int NUM_SCANCODES    = 128,
  parameter int NUM_SHIFT_STATES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_wdata,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_code_byte,
  input  wire logic [3:0]  in_column,
  input  wire logic [15:0] in_entry_value,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_value,
  output logic             out_last
);

  import sc2kc_pkg::*;

  localparam int Depth = NUM_SCANCODES * NUM_SHIFT_STATES;
  localparam int AW    = $clog2(Depth);

  // Configuration registers.
  logic raw_mode_r, reboot_enable_r, table_valid_r;

  // Keyboard state.
  logic [5:0] mods_r;
  logic [2:0] leds_r;
  logic       ext_r;

  // Keymap memories.
  logic [15:0] main_mem [Depth];
  logic [15:0] ext_mem  [Depth];
  logic [15:0] rd_main_r, rd_ext_r;

  // Lookup stage.
  logic       s1_valid_r;
  logic       s1_raw_r, s1_dbg_r, s1_reboot_r, s1_led_r, s1_look_r, s1_ext_r;
  logic [7:0] s1_byte_r;
  logic [2:0] s1_leds_r;

  // Output buffer.
  kind_t      eb_kind_r [MAX_RESULTS];
  logic [7:0] eb_val_r  [MAX_RESULTS];
  logic [1:0] eb_cnt_r, eb_idx_r;

  function automatic logic [5:0] track(input logic [5:0] m, input logic [7:0] sc,
                                       input logic [7:0] code, input logic cond,
                                       input logic [2:0] pos);
    logic [5:0] r;
    r = m;
    if (cond) begin
      if (sc == code) r[pos] = 1'b1;
      if (sc == (code | SC_BREAK)) r[pos] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [3:0] pick_column(input logic [5:0] m, input logic [2:0] l);
    logic any_shift;
    any_shift = m[M_LSHIFT] | m[M_RSHIFT];
    if (any_shift && (l & LED_CAPS) != 3'b0)  return COL_SHIFTCAPS;
    if (m[M_LSHIFT] && m[M_LCTRL])            return COL_SHIFTCTRL;
    if (any_shift)                            return COL_SHIFT;
    if (m[M_LCTRL] || m[M_RCTRL])             return COL_CTRL;
    if (m[M_LALT])                            return COL_ALT;
    if (m[M_RALT])                            return COL_ALTGR;
    if ((l & LED_CAPS) != 3'b0)               return COL_CAPSLOCK;
    if ((l & LED_NUM) != 3'b0)                return COL_NUMLOCK;
    return COL_NORMAL;
  endfunction

  // ---------------------------------------------------------------- decode
  logic       accept, is_scan, wr_main, wr_ext;
  logic       row_ok, col_ok, ctrl_alt, is_prefix, is_dbg, normal;
  logic [2:0] led_toggle, leds_nxt;
  logic [5:0] mods_nxt;
  logic [3:0] rd_col;
  logic [AW-1:0] wr_addr, rd_addr;
  logic       s1_move, eb_busy, eb_take, eb_done;

  assign accept    = in_valid && in_ready;
  assign is_scan   = (in_command == CMD_SCAN);
  assign row_ok    = (32'(in_code_byte) < NUM_SCANCODES);
  assign col_ok    = (32'(in_column) < NUM_SHIFT_STATES);
  assign wr_main   = accept && (in_command == CMD_WR_MAIN) && row_ok && col_ok;
  assign wr_ext    = accept && (in_command == CMD_WR_EXT) && row_ok && col_ok;
  assign ctrl_alt  = mods_r[M_LCTRL] | mods_r[M_LALT];
  assign is_prefix = (in_code_byte == SC_PREFIX_E0);
  assign is_dbg    = ctrl_alt && (in_code_byte == SC_DEBUG);
  // A scancode that goes through full translation and updates state.
  assign normal    = is_scan && !raw_mode_r && table_valid_r && !is_prefix && !is_dbg;

  always_comb begin
    led_toggle = 3'b000;
    case (in_code_byte)
      SC_CAPS:   led_toggle = LED_CAPS;
      SC_NUM:    led_toggle = LED_NUM;
      SC_SCROLL: led_toggle = LED_SCROLL;
      default:   led_toggle = 3'b000;
    endcase
  end

  assign leds_nxt = leds_r ^ led_toggle;

  always_comb begin
    mods_nxt = mods_r;
    mods_nxt = track(mods_nxt, in_code_byte, SC_CTRL,   !ext_r, M_LCTRL);
    mods_nxt = track(mods_nxt, in_code_byte, SC_CTRL,    ext_r, M_RCTRL);
    mods_nxt = track(mods_nxt, in_code_byte, SC_LSHIFT,  1'b1,  M_LSHIFT);
    mods_nxt = track(mods_nxt, in_code_byte, SC_RSHIFT,  1'b1,  M_RSHIFT);
    mods_nxt = track(mods_nxt, in_code_byte, SC_ALT,    !ext_r, M_LALT);
    mods_nxt = track(mods_nxt, in_code_byte, SC_ALT,     ext_r, M_RALT);
  end

  // The column is chosen from the state as it stands after this scancode.
  assign rd_col  = pick_column(mods_nxt, leds_nxt);
  assign wr_addr = AW'(32'(in_code_byte) * NUM_SHIFT_STATES + 32'(in_column));
  assign rd_addr = AW'(32'(in_code_byte) * NUM_SHIFT_STATES + 32'(rd_col));

  // --------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (wr_main) main_mem[wr_addr] <= in_entry_value;
    if (wr_ext)  ext_mem[wr_addr]  <= in_entry_value;
  end

  // Read only when a lookup is launched, so the data holds while it waits.
  always_ff @(posedge clk) begin
    if (accept && normal && row_ok) begin
      rd_main_r <= main_mem[rd_addr];
      rd_ext_r  <= ext_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------- config, state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r      <= 1'b0;
      reboot_enable_r <= 1'b1;
      table_valid_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAW_MODE:      raw_mode_r      <= cfg_wdata;
        CFG_REBOOT_ENABLE: reboot_enable_r <= cfg_wdata;
        CFG_TABLE_VALID:   table_valid_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= 6'b0;
      leds_r <= 3'b0;
      ext_r  <= 1'b0;
    end else if (accept && is_scan && !raw_mode_r && table_valid_r) begin
      if (is_prefix) begin
        ext_r <= 1'b1;
      end else if (!is_dbg) begin
        mods_r <= mods_nxt;
        leds_r <= leds_nxt;
        ext_r  <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- lookup stage
  assign eb_busy  = (eb_cnt_r != 2'd0);
  assign eb_take  = out_valid && out_ready;
  assign eb_done  = eb_take && out_last;
  assign s1_move  = !eb_busy || eb_done;
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= is_scan && (raw_mode_r || (table_valid_r && !is_prefix));
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw_r    <= raw_mode_r;
      s1_dbg_r    <= is_dbg;
      s1_reboot_r <= ctrl_alt && (in_code_byte == SC_DELETE) && reboot_enable_r;
      s1_led_r    <= (led_toggle != 3'b000);
      s1_leds_r   <= leds_nxt;
      s1_look_r   <= row_ok;
      s1_ext_r    <= ext_r;
      s1_byte_r   <= in_code_byte;
    end
  end

  // ------------------------------------------------------ result list build
  kind_t       bl_kind [MAX_RESULTS];
  logic [7:0]  bl_val  [MAX_RESULTS];
  logic [1:0]  bl_cnt;
  logic [15:0] keycode;

  assign keycode = s1_ext_r ? rd_ext_r : rd_main_r;

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bl_kind[i] = KIND_KEY;
      bl_val[i]  = 8'h00;
    end
    bl_cnt = 2'd0;
    if (s1_raw_r) begin
      bl_val[0] = s1_byte_r;
      bl_cnt    = 2'd1;
    end else if (s1_dbg_r) begin
      bl_kind[0] = KIND_DEBUG;
      bl_cnt     = 2'd1;
    end else begin
      if (s1_reboot_r) begin
        bl_kind[bl_cnt] = KIND_REBOOT;
        bl_cnt          = bl_cnt + 2'd1;
      end
      if (s1_led_r) begin
        bl_kind[bl_cnt] = KIND_LED;
        bl_val[bl_cnt]  = {5'b0, s1_leds_r};
        bl_cnt          = bl_cnt + 2'd1;
      end
      if (s1_look_r && keycode != 16'h0000) begin
        bl_val[bl_cnt] = keycode[7:0];
        bl_cnt         = bl_cnt + 2'd1;
        if (keycode[15:8] != 8'h00) begin
          bl_val[bl_cnt] = keycode[15:8];
          bl_cnt         = bl_cnt + 2'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------- output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_cnt_r <= 2'd0;
      eb_idx_r <= 2'd0;
    end else if (s1_valid_r && s1_move) begin
      eb_cnt_r <= bl_cnt;
      eb_idx_r <= 2'd0;
    end else if (eb_done) begin
      eb_cnt_r <= 2'd0;
      eb_idx_r <= 2'd0;
    end else if (eb_take) begin
      eb_idx_r <= eb_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_move) begin
      eb_kind_r <= bl_kind;
      eb_val_r  <= bl_val;
    end
  end

  assign out_valid = eb_busy;
  assign out_kind  = eb_kind_r[eb_idx_r];
  assign out_value = eb_val_r[eb_idx_r];
  assign out_last  = (eb_idx_r == eb_cnt_r - 2'd1);

  // ------------------------------------------------------------- assertions
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(rd_main_r) && $stable(rd_ext_r))
    else $error("keymap read data changed while the lookup stage was stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    eb_busy |-> eb_idx_r < eb_cnt_r)
    else $error("output buffer index beyond its fill count");

  a_debug_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DEBUG |-> out_last && eb_idx_r == 2'd0)
    else $error("debug break not the only result word");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result list ended without a last word");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-1 scancode to keycode translator. The
// keymap rows in use are loaded first, then a directed word list and random
// phases under several register settings and handshake idling patterns run.
// Every accepted input word is run through a local predictor, and each
// result word is compared field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sc2kc_pkg::*;

  localparam int NUM_ROWS      = 128;
  localparam int NUM_COLS      = 10;
  localparam int NUM_LIVE      = 11;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [7:0] KEY_Q    = 8'h10;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  code;
    logic [3:0]  column;
    logic [15:0] entry;
  } word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_RAW_MODE;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_SCAN;
  logic [7:0]  in_code_byte = 8'h00;
  logic [3:0]  in_column = 4'd0;
  logic [15:0] in_entry_value = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic        out_last;

  scancode_to_keycode_translator_unit #(
    .NUM_SCANCODES   (NUM_ROWS),
    .NUM_SHIFT_STATES(NUM_COLS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_code_byte  (in_code_byte),
    .in_column     (in_column),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  always #10 clk = ~clk;

  // Rows loaded in both keymaps in every column but shift+num; only these are ever looked up.
  logic [7:0] live_rows [0:NUM_LIVE-1] = '{
    8'h00, KEY_Q, SC_CTRL, SC_LSHIFT, SC_RSHIFT, SC_ALT,
    SC_CAPS, SC_NUM, SC_SCROLL, SC_DELETE, 8'h7F
  };
  logic [7:0] mod_codes [0:3] = '{SC_CTRL, SC_LSHIFT, SC_RSHIFT, SC_ALT};
  logic [7:0] lock_codes [0:2] = '{SC_CAPS, SC_NUM, SC_SCROLL};

  // Predictor state and register copies.
  logic        raw_on, reboot_on, table_on;
  logic [5:0]  mods;
  logic [2:0]  leds;
  logic        e0_seen;
  logic [15:0] main_map [0:NUM_ROWS*NUM_COLS-1];
  logic [15:0] ext_map [0:NUM_ROWS*NUM_COLS-1];

  word_t   pending_words [$];
  result_t due_results [$];
  word_t   next_word;
  result_t want;
  int      failures = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic logic [3:0] shift_column();
    logic any_shift;
    any_shift = mods[M_LSHIFT] | mods[M_RSHIFT];
    if (any_shift && (leds & LED_CAPS) != 0) return COL_SHIFTCAPS;
    if (mods[M_LSHIFT] && mods[M_LCTRL]) return COL_SHIFTCTRL;
    if (any_shift) return COL_SHIFT;
    if (mods[M_LCTRL] || mods[M_RCTRL]) return COL_CTRL;
    if (mods[M_LALT]) return COL_ALT;
    if (mods[M_RALT]) return COL_ALTGR;
    if ((leds & LED_CAPS) != 0) return COL_CAPSLOCK;
    if ((leds & LED_NUM) != 0) return COL_NUMLOCK;
    return COL_NORMAL;
  endfunction

  // Works out the result words of one accepted input word.
  function automatic void translate_word(word_t w);
    result_t res [$];
    logic        ext;
    logic [15:0] kc;
    int          idx;
    if (w.command == CMD_WR_MAIN || w.command == CMD_WR_EXT) begin
      if (w.code < NUM_ROWS && w.column < NUM_COLS) begin
        idx = int'(w.code) * NUM_COLS + int'(w.column);
        if (w.command == CMD_WR_MAIN) main_map[idx] = w.entry;
        else ext_map[idx] = w.entry;
      end
      return;
    end
    if (w.command != CMD_SCAN) return;
    if (raw_on) begin
      res.push_back('{KIND_KEY, w.code, 1'b0});
    end else if (table_on) begin
      if (w.code == SC_PREFIX_E0) begin
        e0_seen = 1'b1;
      end else if ((mods[M_LCTRL] || mods[M_LALT]) && w.code == SC_DEBUG) begin
        res.push_back('{KIND_DEBUG, 8'h00, 1'b0});
      end else begin
        ext = e0_seen;
        if ((mods[M_LCTRL] || mods[M_LALT]) && w.code == SC_DELETE && reboot_on)
          res.push_back('{KIND_REBOOT, 8'h00, 1'b0});
        if (w.code == SC_CAPS) begin
          leds ^= LED_CAPS;
          res.push_back('{KIND_LED, {5'b0, leds}, 1'b0});
        end
        if (w.code == SC_NUM) begin
          leds ^= LED_NUM;
          res.push_back('{KIND_LED, {5'b0, leds}, 1'b0});
        end
        if (w.code == SC_SCROLL) begin
          leds ^= LED_SCROLL;
          res.push_back('{KIND_LED, {5'b0, leds}, 1'b0});
        end
        // Make code sets the modifier, the same code with bit 7 set clears it.
        if (w.code[6:0] == SC_CTRL[6:0]) mods[ext ? M_RCTRL : M_LCTRL] = !w.code[7];
        if (w.code[6:0] == SC_LSHIFT[6:0]) mods[M_LSHIFT] = !w.code[7];
        if (w.code[6:0] == SC_RSHIFT[6:0]) mods[M_RSHIFT] = !w.code[7];
        if (w.code[6:0] == SC_ALT[6:0]) mods[ext ? M_RALT : M_LALT] = !w.code[7];
        if (w.code < NUM_ROWS) begin
          idx = int'(w.code) * NUM_COLS + int'(shift_column());
          kc = ext ? ext_map[idx] : main_map[idx];
          if (kc != 16'h0000) res.push_back('{KIND_KEY, kc[7:0], 1'b0});
          if (kc > 16'h00FF) res.push_back('{KIND_KEY, kc[15:8], 1'b0});
        end
        e0_seen = 1'b0;
      end
    end
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) due_results.push_back(res[i]);
  endfunction

  function automatic logic [15:0] random_keycode();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'($urandom_range(1, 255));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    int    pick;
    w.command = CMD_SCAN;
    w.code = live_rows[$urandom_range(NUM_LIVE-1)];
    w.column = 4'($urandom_range(15));
    w.entry = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 8) begin
      // Table writes land anywhere, out-of-range rows and columns included.
      w.command = $urandom_range(1) ? CMD_WR_MAIN : CMD_WR_EXT;
      w.code = 8'($urandom_range(255));
      w.entry = random_keycode();
    end else if (pick < 11) begin
      w.command = CMD_NONE;
      w.code = 8'($urandom_range(255));
    end else if (pick < 31) begin
      w.code = mod_codes[$urandom_range(3)] | ($urandom_range(1) ? SC_BREAK : 8'h00);
    end else if (pick < 41) begin
      w.code = SC_PREFIX_E0;
    end else if (pick < 48) begin
      w.code = lock_codes[$urandom_range(2)];
    end else if (pick < 52) begin
      w.code = SC_DEBUG;
    end else if (pick < 57) begin
      w.code = SC_DELETE;
    end else if (pick < 72) begin
      w.code = 8'($urandom_range(128, 255));
    end
    return w;
  endfunction

  task automatic queue_scan(logic [7:0] code);
    pending_words.push_back('{CMD_SCAN, code, 4'($urandom_range(15)),
                              16'($urandom_range(65535))});
  endtask

  // Waits until every word is sent and every result has come, then lets the
  // pipeline settle, since some words cause no result.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic raw, logic reboot, logic tbl);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RAW_MODE;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_index <= CFG_REBOOT_ENABLE;
    cfg_wdata <= reboot;
    @(posedge clk);
    cfg_index <= CFG_TABLE_VALID;
    cfg_wdata <= tbl;
    @(posedge clk);
    cfg_we <= 1'b0;
    raw_on = raw;
    reboot_on = reboot;
    table_on = tbl;
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int count);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_words.push_back(random_word());
    wait_idle();
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        in_command <= next_word.command;
        in_code_byte <= next_word.code;
        in_column <= next_word.column;
        in_entry_value <= next_word.entry;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        translate_word({in_command, in_code_byte, in_column, in_entry_value});
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word: kind %0d value 0x%02h last %0d",
                 out_kind, out_value, out_last);
          failures++;
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            failures++;
          end
          if (out_value !== want.value) begin
            $error("value: expected 0x%02h, got 0x%02h", want.value, out_value);
            failures++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            failures++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    raw_on = 1'b0;
    reboot_on = 1'b1;
    table_on = 1'b1;
    mods = '0;
    leds = '0;
    e0_seen = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    apply_config(1'b0, 1'b1, 1'b1);

    // Load the live rows in both keymaps. The shift+num column is never
    // chosen by the shift logic, so it is left out.
    for (int r = 0; r < NUM_LIVE; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (c == int'(COL_SHIFTNUM)) continue;
        pending_words.push_back('{CMD_WR_MAIN, live_rows[r], 4'(c), random_keycode()});
        pending_words.push_back('{CMD_WR_EXT, live_rows[r], 4'(c), random_keycode()});
      end
    end
    wait_idle();

    // Directed words: row extremes, most shift-state columns, lock keys, debug break,
    // reboot, the prefix byte, ignored commands and out-of-range writes.
    queue_scan(8'h00);
    queue_scan(8'h7F);
    queue_scan(8'hFF);
    queue_scan(SC_CAPS);
    queue_scan(SC_LSHIFT);
    queue_scan(KEY_Q);
    queue_scan(SC_LSHIFT | SC_BREAK);
    queue_scan(KEY_Q);
    queue_scan(SC_CAPS);
    queue_scan(SC_NUM);
    queue_scan(KEY_Q);
    queue_scan(SC_NUM);
    queue_scan(SC_SCROLL);
    queue_scan(SC_CTRL);
    queue_scan(SC_LSHIFT);
    queue_scan(KEY_Q);
    queue_scan(SC_LSHIFT | SC_BREAK);
    queue_scan(SC_DEBUG);
    queue_scan(SC_DELETE);
    queue_scan(SC_CTRL | SC_BREAK);
    queue_scan(SC_PREFIX_E0);
    queue_scan(SC_ALT);
    queue_scan(KEY_Q);
    queue_scan(SC_PREFIX_E0);
    queue_scan(SC_ALT | SC_BREAK);
    queue_scan(SC_PREFIX_E0);
    queue_scan(SC_CAPS);
    pending_words.push_back('{CMD_NONE, 8'hFF, 4'hF, 16'hFFFF});
    pending_words.push_back('{CMD_WR_MAIN, 8'h80, 4'd3, random_keycode()});
    pending_words.push_back('{CMD_WR_EXT, 8'h05, 4'd15, random_keycode()});
    wait_idle();

    run_phase(0, 0, 20);
    apply_config(1'b0, 1'b0, 1'b1);
    run_phase(69, 0, 15);
    apply_config(1'b1, 1'b1, 1'b1);
    run_phase(0, 69, 10);
    apply_config(1'b0, 1'b1, 1'b0);
    run_phase(32, 32, 10);
    apply_config(1'b0, 1'b1, 1'b1);
    run_phase(32, 32, 20);
    apply_config(1'b1, 1'b0, 1'b0);
    run_phase(0, 0, 10);
    apply_config(1'b0, 1'b1, 1'b1);
    run_phase(0, 69, 15);

    if (failures == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
sv/sc2kc_pkg.sv
sv/scancode_to_keycode_translator_unit.sv
bench/tb_top.sv
